FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/gmrc_pkg.sv
package gmrc_pkg;

    localparam int ADDR_BITS_DEFAULT = 48;
    localparam int PAGE_BITS_DEFAULT = 12;
    localparam int SIZE_W            = 22;
    localparam int COUNT_W           = 37;
    localparam int PROT_W            = 3;

    // Protection bit positions.
    localparam int PROT_READ  = 0;
    localparam int PROT_WRITE = 1;
    localparam int PROT_EXEC  = 2;

    // Item kinds.
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [PROT_W-1:0] prot_t;

    // What one item does to the pending run.
    typedef struct packed {
        logic emit;          // pending run goes out as a command
        logic clear;         // run is dropped (flush)
        logic load_new;      // piece starts a new run
        logic extend_after;  // piece appends to the end of the run
        logic extend_before; // piece prepends to the start of the run
    } gmrc_dec_t;

endpackage

FILE: sv/guest_mapping_run_coalescer.sv
// Guest mapping run coalescer. Map items (host address, guest address, byte size and
// read/write/execute bits) are gathered into one pending run; a piece joins the run when
// its protection matches and it sits directly after the run, or directly before it, in
// both the host and the guest space. Any other piece sends the pending run out as one
// mapping command (host start, guest start, count of 2^PAGE_BITS-byte pages, protection)
// and opens a new run. A flush item sends out the pending run, if there is one, and
// empties it. Overlapping pieces are never merged, and all address math wraps at
// ADDR_BITS. A size of zero counts as 4 MiB. Throughput is one item per clock. An
// accepted item waits in the input register, where it is decided, and any command
// it causes is then registered in the output register and presented on the m_ side.
// The only thing that holds the input back is a command in the output register that
// is not yet taken while the input register is also full.
module guest_mapping_run_coalescer #(
    parameter int ADDR_BITS = gmrc_pkg::ADDR_BITS_DEFAULT,
    parameter int PAGE_BITS = gmrc_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [ADDR_BITS-1:0]         s_host_addr,
    input  logic [ADDR_BITS-1:0]         s_guest_addr,
    input  logic [gmrc_pkg::SIZE_W-1:0]  s_size_bytes,
    input  logic                         s_can_read,
    input  logic                         s_can_write,
    input  logic                         s_can_exec,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ADDR_BITS-1:0]         m_host_start,
    output logic [ADDR_BITS-1:0]         m_guest_start,
    output logic [gmrc_pkg::COUNT_W-1:0] m_page_count,
    output logic                         m_run_read,
    output logic                         m_run_write,
    output logic                         m_run_exec
);
    import gmrc_pkg::*;

    // Input register. The end addresses of the piece are computed on the way in, so the
    // decision stage does not have to add the size.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 in_kind_reg;
    logic [ADDR_BITS-1:0] in_h0_reg;
    logic [ADDR_BITS-1:0] in_h1_reg;
    logic [ADDR_BITS-1:0] in_g0_reg;
    logic [ADDR_BITS-1:0] in_g1_reg;
    prot_t                in_prot_reg;

    logic [SIZE_W-1:0]    span;
    logic [ADDR_BITS-1:0] span_ext;
    prot_t                s_prot;
    logic                 s_fire;

    // Pending run. Bounds are inclusive byte addresses.
    logic                 run_valid_reg;
    logic                 run_valid_next;
    logic [ADDR_BITS-1:0] host_first_reg;
    logic [ADDR_BITS-1:0] host_last_reg;
    logic [ADDR_BITS-1:0] guest_first_reg;
    logic [ADDR_BITS-1:0] guest_last_reg;
    prot_t                run_prot_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ADDR_BITS-1:0] out_host_reg;
    logic [ADDR_BITS-1:0] out_guest_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    prot_t                out_prot_reg;

    gmrc_dec_t            dec;
    logic                 out_free;
    logic                 advance;

    // Page count of the pending run: (last - first + 1) >> PAGE_BITS, with one extra bit
    // so that a run covering the whole address space does not wrap to zero.
    logic [ADDR_BITS-1:0] run_diff;
    logic [ADDR_BITS:0]   run_bytes;
    logic [ADDR_BITS:0]   run_pages;

    // The output register is free for a new command when empty or being drained now.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_fire   = s_valid && s_ready;

    // Size minus one wraps inside the size field, so a size of zero spans 4 MiB.
    assign span     = s_size_bytes - SIZE_W'(1);
    assign span_ext = {{(ADDR_BITS-SIZE_W){1'b0}}, span};

    always_comb begin
        s_prot             = '0;
        s_prot[PROT_READ]  = s_can_read;
        s_prot[PROT_WRITE] = s_can_write;
        s_prot[PROT_EXEC]  = s_can_exec;
    end

    assign in_valid_next = s_fire || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_kind_reg <= s_kind;
            in_h0_reg   <= s_host_addr;
            in_h1_reg   <= s_host_addr + span_ext;
            in_g0_reg   <= s_guest_addr;
            in_g1_reg   <= s_guest_addr + span_ext;
            in_prot_reg <= s_prot;
        end
    end

    gmrc_decide #(
        .ADDR_BITS (ADDR_BITS)
    ) u_decide (
        .kind        (in_kind_reg),
        .h0          (in_h0_reg),
        .h1          (in_h1_reg),
        .g0          (in_g0_reg),
        .g1          (in_g1_reg),
        .prot        (in_prot_reg),
        .run_valid   (run_valid_reg),
        .host_first  (host_first_reg),
        .host_last   (host_last_reg),
        .guest_first (guest_first_reg),
        .guest_last  (guest_last_reg),
        .run_prot    (run_prot_reg),
        .dec         (dec)
    );

    // A flush leaves no run behind; every map item leaves one.
    assign run_valid_next = advance ? !dec.clear : run_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
        end else begin
            run_valid_reg <= run_valid_next;
        end
    end

    // The run bounds are only looked at while a run is pending, so they need no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (dec.load_new) begin
                host_first_reg  <= in_h0_reg;
                host_last_reg   <= in_h1_reg;
                guest_first_reg <= in_g0_reg;
                guest_last_reg  <= in_g1_reg;
                run_prot_reg    <= in_prot_reg;
            end
            if (dec.extend_after) begin
                host_last_reg  <= in_h1_reg;
                guest_last_reg <= in_g1_reg;
            end
            if (dec.extend_before) begin
                host_first_reg  <= in_h0_reg;
                guest_first_reg <= in_g0_reg;
            end
        end
    end

    // The command always describes the run as it stood before this item.
    assign run_diff  = host_last_reg - host_first_reg;
    assign run_bytes = {1'b0, run_diff} + (ADDR_BITS + 1)'(1);
    assign run_pages = run_bytes >> PAGE_BITS;

    assign out_valid_next = (advance && dec.emit) || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && dec.emit) begin
            out_host_reg  <= host_first_reg;
            out_guest_reg <= guest_first_reg;
            out_count_reg <= COUNT_W'(run_pages);
            out_prot_reg  <= run_prot_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_host_start  = out_host_reg;
    assign m_guest_start = out_guest_reg;
    assign m_page_count  = out_count_reg;
    assign m_run_read    = out_prot_reg[PROT_READ];
    assign m_run_write   = out_prot_reg[PROT_WRITE];
    assign m_run_exec    = out_prot_reg[PROT_EXEC];

endmodule

FILE: sv/gmrc_decide.sv
module gmrc_decide #(
    parameter int ADDR_BITS = gmrc_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                  kind,
    input  logic [ADDR_BITS-1:0]  h0,
    input  logic [ADDR_BITS-1:0]  h1,
    input  logic [ADDR_BITS-1:0]  g0,
    input  logic [ADDR_BITS-1:0]  g1,
    input  gmrc_pkg::prot_t       prot,
    input  logic                  run_valid,
    input  logic [ADDR_BITS-1:0]  host_first,
    input  logic [ADDR_BITS-1:0]  host_last,
    input  logic [ADDR_BITS-1:0]  guest_first,
    input  logic [ADDR_BITS-1:0]  guest_last,
    input  gmrc_pkg::prot_t       run_prot,
    output gmrc_pkg::gmrc_dec_t   dec
);
    import gmrc_pkg::*;

    logic [ADDR_BITS-1:0] host_last_inc;
    logic [ADDR_BITS-1:0] guest_last_inc;
    logic [ADDR_BITS-1:0] h1_inc;
    logic [ADDR_BITS-1:0] g1_inc;
    logic                 is_flush;
    logic                 prot_eq;
    logic                 join_after;
    logic                 join_before;

    // All address arithmetic wraps at the address width.
    assign host_last_inc  = host_last + ADDR_BITS'(1);
    assign guest_last_inc = guest_last + ADDR_BITS'(1);
    assign h1_inc         = h1 + ADDR_BITS'(1);
    assign g1_inc         = g1 + ADDR_BITS'(1);

    assign is_flush    = (kind == KIND_FLUSH);
    assign prot_eq     = (prot == run_prot);
    assign join_after  = prot_eq && (host_last_inc == h0) && (guest_last_inc == g0);
    assign join_before = prot_eq && (h1_inc == host_first) && (g1_inc == guest_first);

    always_comb begin
        dec = '0;
        priority if (is_flush) begin
            dec.emit  = run_valid;
            dec.clear = 1'b1;
        end else if (!run_valid) begin
            dec.load_new = 1'b1;
        end else if (join_after) begin
            dec.extend_after = 1'b1;
        end else if (join_before) begin
            dec.extend_before = 1'b1;
        end else begin
            dec.emit     = 1'b1;
            dec.load_new = 1'b1;
        end
    end

endmodule

FILE: sv/gmrc_checker.sv
`include "assert_macros.svh"

module gmrc_checker #(
    parameter int ADDR_BITS = gmrc_pkg::ADDR_BITS_DEFAULT
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ADDR_BITS-1:0]         m_host_start,
    input logic [ADDR_BITS-1:0]         m_guest_start,
    input logic [gmrc_pkg::COUNT_W-1:0] m_page_count,
    input logic                         m_run_read,
    input logic                         m_run_write,
    input logic                         m_run_exec
);
    import gmrc_pkg::*;

    // A command that is not taken stays presented.
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid,
        "result item dropped before it was taken")

    // Its contents stay put while it waits.
    `ASSERT_CLKD(a_out_stable, aclk, aresetn,
        m_valid && !m_ready |=> $stable(m_host_start) && $stable(m_guest_start)
            && $stable(m_page_count) && $stable(m_run_read) && $stable(m_run_write)
            && $stable(m_run_exec),
        "result item changed while stalled")

    // The input is only held back by a command waiting on the output side.
    `ASSERT_CLKD(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready,
        "input stalled without a waiting result item")

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid,
        "result item presented right after reset")

endmodule

bind guest_mapping_run_coalescer gmrc_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_gmrc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_host_start  (m_host_start),
    .m_guest_start (m_guest_start),
    .m_page_count  (m_page_count),
    .m_run_read    (m_run_read),
    .m_run_write   (m_run_write),
    .m_run_exec    (m_run_exec)
);
